// ===== rtl/ple_pkg.sv =====
// Shared types and constants for the positional list engine.
// No dependencies; imported by ple_ctrl and the top level.
package ple_pkg;

  localparam int unsigned CAPACITY_DEF = 32;
  localparam int unsigned VALUE_W_DEF  = 32;

  localparam int unsigned ACT_W     = 2;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned IN_VAL_W  = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CNT_OUT_W = 6;
  localparam int unsigned ELEM_W    = 32;

  // position | value, rounded up to whole bytes (already 40)
  localparam int unsigned S_TDATA_W = ((POS_W + IN_VAL_W + 7) / 8) * 8;
  // status | element_count | element
  localparam int unsigned M_TDATA_W = ((STATUS_W + CNT_OUT_W + ELEM_W + 7) / 8) * 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_READ   = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_POS = 2'd1,
    STAT_FULL    = 2'd2
  } status_e;

endpackage

// ===== rtl/ple_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
module ple_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds while re_i is low
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ple_ctrl.sv =====
// Sequencer for the positional list engine: decodes operations, walks the
// element memory to shift entries or stream them out, and holds the output beat.
// Depends on ple_pkg; drives one ple_ram instance.
module ple_ctrl #(
  parameter int unsigned CAPACITY    = 32,
  parameter int unsigned VALUE_WIDTH = 32,
  localparam int unsigned ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  input  logic [ple_pkg::S_TDATA_W-1:0] s_tdata_i,
  input  logic [ple_pkg::ACT_W-1:0]     s_tuser_i,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [ple_pkg::M_TDATA_W-1:0] m_tdata_o,
  output logic                          m_tlast_o,
  output logic                          ram_we_o,
  output logic [ADDR_W-1:0]             ram_waddr_o,
  output logic [VALUE_WIDTH-1:0]        ram_wdata_o,
  output logic                          ram_re_o,
  output logic [ADDR_W-1:0]             ram_raddr_o,
  input  logic [VALUE_WIDTH-1:0]        ram_rdata_i
);

  import ple_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UP   = 2'd1;
  localparam logic [1:0] S_DN   = 2'd2;
  localparam logic [1:0] S_RD   = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [ADDR_W-1:0]      idx_q, idx_d;
  logic [ADDR_W-1:0]      pos0_q, pos0_d;
  logic [ADDR_W-1:0]      wr_addr_q, wr_addr_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic                   wpend_q, wpend_d;
  logic                   rd_pend_q, rd_pend_d;
  logic                   rd_more_q, rd_more_d;
  logic                   rd_last_q, rd_last_d;

  logic                   out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]    out_status_q, out_status_d;
  logic [CNT_W-1:0]       out_cnt_q, out_cnt_d;
  logic [ELEM_W-1:0]      out_elem_q, out_elem_d;
  logic                   out_last_q, out_last_d;

  logic                   out_free;
  logic                   load_out;
  logic [POS_W-1:0]       in_pos;
  logic [IN_VAL_W-1:0]    in_val;
  logic [POS_W:0]         pos_x;
  logic [POS_W:0]         cnt_x;
  logic [POS_W-1:0]       pos_m1;
  logic [CNT_W-1:0]       cnt_m1;
  logic                   is_full;
  logic [63+IN_VAL_W:0]   in_sx;
  logic [VALUE_WIDTH+ELEM_W-1:0] rd_sx;
  logic [CNT_W+CNT_OUT_W-1:0]    cnt_out_x;

  assign in_pos  = s_tdata_i[POS_W-1:0];
  assign in_val  = s_tdata_i[POS_W+IN_VAL_W-1:POS_W];
  assign pos_x   = {1'b0, in_pos};
  assign cnt_x   = (POS_W + 1)'(cnt_q);
  assign pos_m1  = in_pos - POS_W'(1);
  assign cnt_m1  = cnt_q - CNT_W'(1);
  assign is_full = (cnt_q == CNT_W'(CAPACITY));
  // value kept as its low VALUE_WIDTH bits, sign-extended
  assign in_sx   = {{64{in_val[IN_VAL_W-1]}}, in_val};
  assign rd_sx   = {{ELEM_W{ram_rdata_i[VALUE_WIDTH-1]}}, ram_rdata_i};
  assign out_free = !out_valid_q || m_tready_i;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    pos0_d       = pos0_q;
    wr_addr_d    = wr_addr_q;
    val_d        = val_q;
    wpend_d      = wpend_q;
    rd_pend_d    = rd_pend_q;
    rd_more_d    = rd_more_q;
    rd_last_d    = rd_last_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_cnt_d    = out_cnt_q;
    out_elem_d   = out_elem_q;
    out_last_d   = out_last_q;
    load_out     = 1'b0;
    s_tready_o   = 1'b0;
    ram_we_o     = 1'b0;
    ram_waddr_o  = wr_addr_q;
    ram_wdata_o  = ram_rdata_i;
    ram_re_o     = 1'b0;
    ram_raddr_o  = idx_q;

    if (out_valid_q && m_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        s_tready_o = out_free;
        if (s_tvalid_i && out_free) begin
          unique case (action_e'(s_tuser_i))
            ACT_INSERT: begin
              if (is_full) begin
                load_out     = 1'b1;
                out_status_d = STAT_FULL;
              end else if (in_pos == '0 || pos_x > cnt_x + (POS_W + 1)'(1)) begin
                load_out     = 1'b1;
                out_status_d = STAT_BAD_POS;
              end else begin
                pos0_d  = pos_m1[ADDR_W-1:0];
                idx_d   = cnt_q[ADDR_W-1:0];
                val_d   = in_sx[VALUE_WIDTH-1:0];
                wpend_d = 1'b0;
                state_d = S_UP;
              end
            end
            ACT_DELETE: begin
              if (in_pos == '0 || pos_x > cnt_x) begin
                load_out     = 1'b1;
                out_status_d = STAT_BAD_POS;
              end else begin
                idx_d   = pos_m1[ADDR_W-1:0];
                wpend_d = 1'b0;
                state_d = S_DN;
              end
            end
            ACT_READ: begin
              if (cnt_q == '0) begin
                load_out     = 1'b1;
                out_status_d = STAT_OK;
              end else begin
                idx_d     = '0;
                rd_more_d = 1'b1;
                rd_pend_d = 1'b0;
                state_d   = S_RD;
              end
            end
            default: ;
          endcase
          out_elem_d = '0;
          out_last_d = 1'b1;
        end
      end

      // insert: move entries up from the tail, read idx-1 then write idx
      S_UP: begin
        if (wpend_q) begin
          ram_we_o = 1'b1;
          wpend_d  = 1'b0;
        end
        if (idx_q != pos0_q) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = idx_q - ADDR_W'(1);
          wr_addr_d   = idx_q;
          idx_d       = idx_q - ADDR_W'(1);
          wpend_d     = 1'b1;
        end else if (!wpend_q && out_free) begin
          ram_we_o     = 1'b1;
          ram_waddr_o  = pos0_q;
          ram_wdata_o  = val_q;
          cnt_d        = cnt_q + CNT_W'(1);
          load_out     = 1'b1;
          out_status_d = STAT_OK;
          out_elem_d   = '0;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      // delete: move entries down toward the hole, read idx+1 then write idx
      S_DN: begin
        if (wpend_q) begin
          ram_we_o = 1'b1;
          wpend_d  = 1'b0;
        end
        if (CNT_W'(idx_q) != cnt_m1) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = idx_q + ADDR_W'(1);
          wr_addr_d   = idx_q;
          idx_d       = idx_q + ADDR_W'(1);
          wpend_d     = 1'b1;
        end else if (!wpend_q && out_free) begin
          cnt_d        = cnt_m1;
          load_out     = 1'b1;
          out_status_d = STAT_OK;
          out_elem_d   = '0;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      // stream: one read in flight; the next read is issued once the previous beat is loaded
      S_RD: begin
        if (rd_pend_q && out_free) begin
          load_out     = 1'b1;
          out_status_d = STAT_OK;
          out_elem_d   = rd_sx[ELEM_W-1:0];
          out_last_d   = rd_last_q;
          rd_pend_d    = 1'b0;
        end
        if (rd_more_q && (!rd_pend_q || out_free)) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = idx_q;
          rd_pend_d   = 1'b1;
          rd_last_d   = (CNT_W'(idx_q) == cnt_m1);
          if (CNT_W'(idx_q) == cnt_m1) begin
            rd_more_d = 1'b0;
          end else begin
            idx_d = idx_q + ADDR_W'(1);
          end
        end
        if (!rd_more_q && !rd_pend_q) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    if (load_out) begin
      out_valid_d = 1'b1;
      out_cnt_d   = cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      wpend_q     <= 1'b0;
      rd_pend_q   <= 1'b0;
      rd_more_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      wpend_q     <= wpend_d;
      rd_pend_q   <= rd_pend_d;
      rd_more_q   <= rd_more_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    pos0_q       <= pos0_d;
    wr_addr_q    <= wr_addr_d;
    val_q        <= val_d;
    rd_last_q    <= rd_last_d;
    out_status_q <= out_status_d;
    out_cnt_q    <= out_cnt_d;
    out_elem_q   <= out_elem_d;
    out_last_q   <= out_last_d;
  end

  // count field is 6 bits wide whatever the capacity
  assign cnt_out_x  = {{CNT_OUT_W{1'b0}}, out_cnt_q};
  assign m_tvalid_o = out_valid_q;
  assign m_tlast_o  = out_last_q;
  assign m_tdata_o  = {out_elem_q, cnt_out_x[CNT_OUT_W-1:0], out_status_q};

endmodule

// ===== rtl/positional_list_engine_unit.sv =====
// Positional list engine: an ordered list of signed values kept in one
// simple dual-port RAM. Insert at position p into a list of c elements
// shifts c-p+1 entries, one per cycle through the RAM (read one entry, write
// it back one place over), then writes the new value and returns to idle.
// Delete shifts c-p entries and then returns to idle. A read issues one RAM
// read per cycle while the output register takes its beats, with one read in
// flight, and returns to idle once its last beat is loaded. An empty read,
// a full store or a bad position answers in one beat with no memory work.
// Output stalls can hold up all of these. The next item is taken only while
// the engine is in idle and the output register is empty or being emptied
// in that cycle. The RAM needs no clearing after reset: only entries below
// the count are ever read. Depends on ple_pkg, ple_ram and ple_ctrl.
module positional_list_engine_unit #(
  parameter int unsigned CAPACITY    = ple_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH = ple_pkg::VALUE_W_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [ple_pkg::S_TDATA_W-1:0] s_axis_tdata_i,  // position[7:0], value[39:8]
  input  logic [ple_pkg::ACT_W-1:0]     s_axis_tuser_i,  // action[1:0]
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [ple_pkg::M_TDATA_W-1:0] m_axis_tdata_o,  // status[1:0], element_count[7:2],
                                                         // element[39:8]
  output logic                          m_axis_tlast_o
);

  import ple_pkg::*;

  localparam int unsigned ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  ple_ctrl #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_o  (s_axis_tready_o),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tuser_i   (s_axis_tuser_i),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_o   (m_axis_tdata_o),
    .m_tlast_o   (m_axis_tlast_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  ple_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// ===== tb/sv/ple_list_checker.sv =====
// Checker for the positional list engine: watches both stream channels,
// keeps its own copy of the list and compares every output beat.
// Depends on ple_pkg.
`timescale 1ns / 1ps

module ple_list_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [ple_pkg::S_TDATA_W-1:0] s_tdata_i,
  input  logic [ple_pkg::ACT_W-1:0]     s_tuser_i,
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic [ple_pkg::M_TDATA_W-1:0] m_tdata_i,
  input  logic                          m_tlast_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o,
  output int unsigned                   list_len_o
);

  import ple_pkg::*;

  typedef struct packed {
    status_e                status;
    logic [CNT_OUT_W-1:0]   count;
    logic [ELEM_W-1:0]      element;
    logic                   last;
  } list_beat_t;

  list_beat_t        pending_beats[$];
  logic [ELEM_W-1:0] cells[CAPACITY_DEF];
  int unsigned       list_len = 0;
  int unsigned       fails = 0;

  assign fail_count_o = fails;
  assign list_len_o   = list_len;

  task automatic push_beat(input status_e st, input logic [ELEM_W-1:0] el, input logic lst);
    list_beat_t b;
    b.status  = st;
    b.count   = list_len[CNT_OUT_W-1:0];
    b.element = el;
    b.last    = lst;
    pending_beats.push_back(b);
  endtask

  // Updates the list copy for one accepted beat and queues what it should produce.
  task automatic apply_list_op(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                               input logic [IN_VAL_W-1:0] val);
    int i;
    case (act)
      ACT_INSERT: begin
        // full check wins over position check
        if (list_len >= CAPACITY_DEF) begin
          push_beat(STAT_FULL, '0, 1'b1);
        end else if (pos < 1 || pos > list_len + 1) begin
          push_beat(STAT_BAD_POS, '0, 1'b1);
        end else begin
          for (i = int'(list_len); i >= int'(pos); i--) cells[i] = cells[i-1];
          cells[pos-1] = val;
          list_len++;
          push_beat(STAT_OK, '0, 1'b1);
        end
      end
      ACT_DELETE: begin
        if (pos < 1 || pos > list_len) begin
          push_beat(STAT_BAD_POS, '0, 1'b1);
        end else begin
          for (i = int'(pos) - 1; i + 1 < int'(list_len); i++) cells[i] = cells[i+1];
          list_len--;
          push_beat(STAT_OK, '0, 1'b1);
        end
      end
      ACT_READ: begin
        if (list_len == 0) begin
          push_beat(STAT_OK, '0, 1'b1);
        end else begin
          for (i = 0; i < int'(list_len); i++)
            push_beat(STAT_OK, cells[i], (i + 1) == int'(list_len));
        end
      end
      default: ;  // unused action: dropped silently
    endcase
  endtask

  task automatic check_beat();
    list_beat_t got;
    list_beat_t want;
    got.status  = status_e'(m_tdata_i[STATUS_W-1:0]);
    got.count   = m_tdata_i[STATUS_W +: CNT_OUT_W];
    got.element = m_tdata_i[STATUS_W+CNT_OUT_W +: ELEM_W];
    got.last    = m_tlast_i;
    if (pending_beats.size() == 0) begin
      fails++;
      if (fails <= 10)
        $display("%0t: unexpected beat status=%0d count=%0d element=%h last=%b",
                 $time, got.status, got.count, got.element, got.last);
    end else begin
      want = pending_beats.pop_front();
      if (got !== want) begin
        fails++;
        if (fails <= 10) begin
          $display("%0t: mismatch exp status=%0d count=%0d element=%h last=%b",
                   $time, want.status, want.count, want.element, want.last);
          $display("%0t:          got status=%0d count=%0d element=%h last=%b",
                   $time, got.status, got.count, got.element, got.last);
        end
      end
    end
  endtask

  // input beat handled first so a same-edge result would find its expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_beats.delete();
      list_len = 0;
      pending_o = 0;
    end else begin
      if (s_tvalid_i && s_tready_i)
        apply_list_op(s_tuser_i, s_tdata_i[POS_W-1:0], s_tdata_i[POS_W +: IN_VAL_W]);
      if (m_tvalid_i && m_tready_i) check_beat();
      pending_o = pending_beats.size();
    end
  end

endmodule

// ===== tb/sv/positional_list_engine_unit_tb.sv =====
// Top of the positional list engine testbench: clock, reset, directed and
// random list operations with random stalls on both channels, and the verdict.
// Depends on ple_pkg, positional_list_engine_unit and ple_list_checker.
`timescale 1ns / 1ps

module positional_list_engine_unit_tb;
  import ple_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [ACT_W-1:0]     s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tlast;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned list_len;
  int unsigned send_idle = 26;
  int unsigned recv_idle = 45;

  positional_list_engine_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  ple_list_checker list_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tlast_i    (m_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .list_len_o   (list_len)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  initial begin
    #10_000_000;
    $display("positional_list_engine_unit_tb: FAIL");
    $finish;
  end

  // returns at the falling edge after the beat was taken, tvalid still high
  task automatic send_beat(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                           input logic [IN_VAL_W-1:0] val);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {val, pos};
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
  endtask

  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic random_item(input bit grow, output logic [ACT_W-1:0] act,
                             output logic [POS_W-1:0] pos, output logic [IN_VAL_W-1:0] val);
    int unsigned r;
    int unsigned hi;
    r = $urandom_range(0, 99);
    if (r < 8)                     act = ACT_READ;
    else if (r < 10)               act = ACT_UNUSED;
    else if (r < (grow ? 90 : 25)) act = ACT_INSERT;
    else                           act = ACT_DELETE;
    hi = (act == ACT_INSERT) ? list_len + 1 : list_len;
    r = $urandom_range(0, 99);
    if (r < 80 && hi >= 1)  pos = POS_W'($urandom_range(1, hi));
    else if (r < 88)        pos = $urandom_range(0, 1) ? POS_W'(1) : POS_W'(hi);
    else                    pos = POS_W'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7fff_ffff;
        2:       val = 32'h0000_0000;
        default: val = 32'hffff_ffff;
      endcase
    end else begin
      val = $urandom;
    end
  endtask

  // fill toward capacity, linger at full, then drain toward empty, and so on
  task automatic run_phase(input int unsigned s_idle, input int unsigned r_idle,
                           input int unsigned n_items);
    int unsigned      done;
    bit               grow;
    logic [ACT_W-1:0] act;
    logic [POS_W-1:0] pos;
    logic [IN_VAL_W-1:0] val;
    send_idle = s_idle;
    recv_idle = r_idle;
    done = 0;
    grow = 1'b1;
    while (done < n_items) begin
      random_item(grow, act, pos, val);
      send_beat(act, pos, val);
      if (act != ACT_UNUSED) done++;
      if (list_len >= CAPACITY_DEF && $urandom_range(0, 3) == 0) grow = 1'b0;
      else if (list_len == 0 && $urandom_range(0, 3) == 0)       grow = 1'b1;
    end
    hold_until_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty list, bad positions, first/last/middle insert and delete
    send_beat(ACT_READ,   8'd0,   32'h0);
    send_beat(ACT_DELETE, 8'd1,   32'h0);
    send_beat(ACT_DELETE, 8'd0,   32'h0);
    send_beat(ACT_INSERT, 8'd0,   32'h1234_5678);
    send_beat(ACT_INSERT, 8'd2,   32'h1234_5678);
    send_beat(ACT_INSERT, 8'd1,   32'h7fff_ffff);
    send_beat(ACT_INSERT, 8'd1,   32'h8000_0000);
    send_beat(ACT_INSERT, 8'd3,   32'hffff_ffff);
    send_beat(ACT_INSERT, 8'd2,   32'h0000_0000);
    send_beat(ACT_INSERT, 8'd255, 32'hdead_beef);
    send_beat(ACT_INSERT, 8'd6,   32'hdead_beef);
    send_beat(ACT_READ,   8'd0,   32'h0);
    send_beat(ACT_UNUSED, 8'd1,   32'hffff_ffff);
    send_beat(ACT_DELETE, 8'd255, 32'h0);
    send_beat(ACT_DELETE, 8'd5,   32'h0);
    send_beat(ACT_DELETE, 8'd4,   32'h0);
    send_beat(ACT_DELETE, 8'd1,   32'h0);
    send_beat(ACT_DELETE, 8'd2,   32'h0);
    send_beat(ACT_READ,   8'd0,   32'h0);
    send_beat(ACT_INSERT, 8'd2,   32'h5a5a_5a5a);
    send_beat(ACT_READ,   8'd0,   32'h0);
    hold_until_drained();

    run_phase(26, 45, 103);
    run_phase(45, 26, 103);
    run_phase(0, 0, 103);

    repeat (100) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("positional_list_engine_unit_tb: PASS");
    end else begin
      $display("positional_list_engine_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
